>>> rtl/rtc_pkg.sv
package rtc_pkg;

  localparam int VALUE_BITS = 64;

  localparam int BIN_DIGITS = VALUE_BITS;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;

  // The emit shifter is wide enough to hold whole octal or hex groups.
  localparam int SR_W = (3 * OCT_DIGITS > 4 * HEX_DIGITS) ? 3 * OCT_DIGITS : 4 * HEX_DIGITS;

  localparam int CNT_W = $clog2(VALUE_BITS + 2);
  localparam int REM_W = $clog2(BIN_DIGITS + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_RADIX = 1'b0,
    CFG_DEST_RADIX   = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  typedef enum logic {
    FUNC_PARSE  = 1'b0,
    FUNC_FORMAT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_BAD  = 2'd1,
    STATUS_SAT  = 2'd2,
    STATUS_ZERO = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_EMIT,
    ST_FLAG
  } state_e;

  localparam logic [7:0] CHAR_0     = 8'd48;
  localparam logic [7:0] CHAR_1     = 8'd49;
  localparam logic [7:0] CHAR_7     = 8'd55;
  localparam logic [7:0] CHAR_9     = 8'd57;
  localparam logic [7:0] CHAR_LA    = 8'd97;
  localparam logic [7:0] CHAR_LF    = 8'd102;
  localparam logic [7:0] CHAR_UA    = 8'd65;
  localparam logic [7:0] CHAR_UF    = 8'd70;
  localparam logic [7:0] CHAR_LB    = 8'd98;
  localparam logic [7:0] CHAR_LO    = 8'd111;
  localparam logic [7:0] CHAR_LX    = 8'd120;
  localparam logic [7:0] LOWER_OFS  = 8'd87;
  localparam logic [7:0] UPPER_OFS  = 8'd55;

  localparam logic [CNT_W-1:0] BIN_LIMIT = CNT_W'(BIN_DIGITS);
  localparam logic [CNT_W-1:0] OCT_LIMIT = CNT_W'(OCT_DIGITS);
  localparam logic [CNT_W-1:0] HEX_LIMIT = CNT_W'(HEX_DIGITS);

endpackage

>>> rtl/radix_text_converter_unit.sv
// Parse: one character beat per cycle; in_ready_o stays high through characters
// without end_of_text, so they can follow back to back.
// An end_of_text character or an integer beat loads a digit shifter (64/22/16 groups for
// binary/octal/hex) that drops one leading zero group or, while the output is not stalled,
// sends one digit beat per cycle; invalid text sends one flag beat instead. The next input
// beat is taken only once the last beat of the result has been issued.
// rst_ni clears the run state and the output beat, and sets source hex, dest binary.
module radix_text_converter_unit
  import rtc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [7:0]            symbol_i,
  input  logic                  end_of_text_i,
  input  logic [63:0]           number_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            digit_char_o,
  output logic [1:0]            status_o,
  output logic                  last_digit_o
);

  logic [1:0]            src_radix_q, dst_radix_q;

  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  bad_q, bad_d;
  logic [1:0]            pos_q, pos_d;
  logic                  pzs_q, pzs_d;

  state_e                state_q, state_d;
  logic [SR_W-1:0]       sr_q, sr_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [1:0]            emit_radix_q, emit_radix_d;
  logic [1:0]            st_q, st_d;

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_char_q, out_char_d;
  logic [1:0]            out_status_q, out_status_d;
  logic                  out_last_q, out_last_d;

  // Character decode.
  logic [7:0]            prefix_letter;
  logic [CNT_W-1:0]      src_limit;
  logic                  dig_ok;
  logic [3:0]            dig_val;
  logic                  dropped;
  logic                  in_fire;
  logic                  out_free;

  // Emit side.
  logic [3:0]            top_dig;
  logic [SR_W-1:0]       sr_shifted;
  logic [REM_W-1:0]      emit_groups;
  logic [7:0]            top_char;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_radix_q <= RADIX_HEX;
      dst_radix_q <= RADIX_BIN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SOURCE_RADIX: src_radix_q <= cfg_data_i;
        CFG_DEST_RADIX:   dst_radix_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (src_radix_q)
      RADIX_BIN: begin
        prefix_letter = CHAR_LB;
        src_limit     = BIN_LIMIT;
      end
      RADIX_OCT: begin
        prefix_letter = CHAR_LO;
        src_limit     = OCT_LIMIT;
      end
      default: begin
        prefix_letter = CHAR_LX;
        src_limit     = HEX_LIMIT;
      end
    endcase
  end

  always_comb begin
    logic [7:0] diff;
    diff    = symbol_i - CHAR_0;
    dig_ok  = 1'b0;
    dig_val = diff[3:0];
    unique case (src_radix_q)
      RADIX_BIN: dig_ok = (symbol_i == CHAR_0) || (symbol_i == CHAR_1);
      RADIX_OCT: dig_ok = (symbol_i >= CHAR_0) && (symbol_i <= CHAR_7);
      default: begin
        if ((symbol_i >= CHAR_0) && (symbol_i <= CHAR_9)) begin
          dig_ok = 1'b1;
        end else if ((symbol_i >= CHAR_LA) && (symbol_i <= CHAR_LF)) begin
          dig_ok = 1'b1;
          diff   = symbol_i - LOWER_OFS;
        end else if ((symbol_i >= CHAR_UA) && (symbol_i <= CHAR_UF)) begin
          dig_ok = 1'b1;
          diff   = symbol_i - UPPER_OFS;
        end
        dig_val = diff[3:0];
      end
    endcase
  end

  assign dropped = (pos_q == 2'd1) && pzs_q && (symbol_i == prefix_letter);

  // Top digit of the shifter, read at the top of the group span of the radix.
  always_comb begin
    unique case (emit_radix_q)
      RADIX_BIN: begin
        top_dig    = {3'b000, sr_q[BIN_DIGITS-1]};
        sr_shifted = {sr_q[SR_W-2:0], 1'b0};
      end
      RADIX_OCT: begin
        top_dig    = {1'b0, sr_q[3*OCT_DIGITS-1 -: 3]};
        sr_shifted = {sr_q[SR_W-4:0], 3'b000};
      end
      default: begin
        top_dig    = sr_q[4*HEX_DIGITS-1 -: 4];
        sr_shifted = {sr_q[SR_W-5:0], 4'b0000};
      end
    endcase
    top_char = (top_dig < 4'd10) ? (8'(top_dig) + CHAR_0) : (8'(top_dig) + LOWER_OFS);
  end

  always_comb begin
    unique case (dst_radix_q)
      RADIX_BIN: emit_groups = REM_W'(BIN_DIGITS);
      RADIX_OCT: emit_groups = REM_W'(OCT_DIGITS);
      default:   emit_groups = REM_W'(HEX_DIGITS);
    endcase
  end

  always_comb begin
    logic [VALUE_BITS-1:0] acc_n;
    logic [CNT_W-1:0]      cnt_n;
    logic                  bad_n;

    acc_d        = acc_q;
    cnt_d        = cnt_q;
    bad_d        = bad_q;
    pos_d        = pos_q;
    pzs_d        = pzs_q;
    state_d      = state_q;
    sr_d         = sr_q;
    rem_d        = rem_q;
    emit_radix_d = emit_radix_q;
    st_d         = st_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_char_d   = out_char_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    acc_n = acc_q;
    cnt_n = cnt_q;
    bad_n = bad_q;
    if (dropped) begin
      acc_n = '0;
      cnt_n = '0;
    end else if (!dig_ok) begin
      bad_n = 1'b1;
    end else if (cnt_q <= src_limit) begin
      unique case (src_radix_q)
        RADIX_BIN: acc_n = {acc_q[VALUE_BITS-2:0], dig_val[0]};
        RADIX_OCT: acc_n = {acc_q[VALUE_BITS-4:0], dig_val[2:0]};
        default:   acc_n = {acc_q[VALUE_BITS-5:0], dig_val};
      endcase
      cnt_n = cnt_q + 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          emit_radix_d = dst_radix_q;
          rem_d        = emit_groups;
          if (func_i == FUNC_FORMAT) begin
            sr_d    = SR_W'(number_i[VALUE_BITS-1:0]);
            st_d    = STATUS_OK;
            state_d = ST_SKIP;
          end else begin
            acc_d = acc_n;
            cnt_d = cnt_n;
            bad_d = bad_n;
            if (pos_q == 2'd0) begin
              pzs_d = (symbol_i == CHAR_0);
            end
            if (pos_q != 2'd2) begin
              pos_d = pos_q + 2'd1;
            end
            if (end_of_text_i) begin
              acc_d = '0;
              cnt_d = '0;
              bad_d = 1'b0;
              pos_d = 2'd0;
              pzs_d = 1'b0;
              priority if (bad_n) begin
                st_d    = STATUS_BAD;
                state_d = ST_FLAG;
              end else if (cnt_n > src_limit) begin
                sr_d    = SR_W'({VALUE_BITS{1'b1}});
                st_d    = STATUS_SAT;
                state_d = ST_SKIP;
              end else begin
                sr_d    = SR_W'(acc_n);
                st_d    = STATUS_OK;
                state_d = ST_SKIP;
              end
            end
          end
        end
      end
      ST_SKIP: begin
        if ((top_dig == 4'd0) && (rem_q > REM_W'(1))) begin
          sr_d  = sr_shifted;
          rem_d = rem_q - 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          if (top_dig == 4'd0) begin
            // Every group was zero: one beat with no digit.
            out_char_d   = 8'd0;
            out_status_d = STATUS_ZERO;
            out_last_d   = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            out_char_d   = top_char;
            out_status_d = st_q;
            out_last_d   = (rem_q == REM_W'(1));
            sr_d         = sr_shifted;
            rem_d        = rem_q - 1'b1;
            state_d      = (rem_q == REM_W'(1)) ? ST_IDLE : ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_char_d   = top_char;
          out_status_d = st_q;
          out_last_d   = (rem_q == REM_W'(1));
          sr_d         = sr_shifted;
          rem_d        = rem_q - 1'b1;
          if (rem_q == REM_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLAG: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_char_d   = 8'd0;
          out_status_d = st_q;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
      pos_q       <= 2'd0;
      pzs_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      bad_q       <= bad_d;
      pos_q       <= pos_d;
      pzs_q       <= pzs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q         <= sr_d;
    rem_q        <= rem_d;
    emit_radix_q <= emit_radix_d;
    st_q         <= st_d;
    out_char_q   <= out_char_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign status_o     = out_status_q;
  assign last_digit_o = out_last_q;

  a_emit_has_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (rem_q != '0))
    else $error("digit emission with no groups left");

  a_no_digit_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((status_o == STATUS_ZERO) || (status_o == STATUS_BAD)))
      |-> (last_digit_o && (digit_char_o == 8'd0)))
    else $error("zero or invalid result must be a single empty beat");

  a_mid_text_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (func_i == FUNC_PARSE) && !end_of_text_i) |=> (state_q == ST_IDLE))
    else $error("a character without end of text started emission");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (BIN_LIMIT + 1'b1))
    else $error("digit count ran past the saturation mark");

  a_digit_beat_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((status_o == STATUS_OK) || (status_o == STATUS_SAT)))
      |-> (((digit_char_o >= CHAR_0) && (digit_char_o <= CHAR_9))
           || ((digit_char_o >= CHAR_LA) && (digit_char_o <= CHAR_LF))))
    else $error("digit beat carries a non-digit character");

endmodule

>>> test/tb_radix_text_converter_unit.sv
module tb_radix_text_converter_unit;
  import rtc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [1:0] RADIX_ALT_HEX = 2'd3;

  typedef struct {
    func_e       func;
    logic [7:0]  symbol;
    logic        eot;
    logic [63:0] number;
  } text_item_t;

  typedef struct {
    logic [7:0] ch;
    status_e    status;
    logic       last;
  } digit_beat_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  func_i = 1'b0;
  logic [7:0]            symbol_i = '0;
  logic                  end_of_text_i = 1'b0;
  logic [63:0]           number_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [7:0]            digit_char_o;
  logic [1:0]            status_o;
  logic                  last_digit_o;

  radix_text_converter_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: register copies and the text run in progress.
  logic [1:0]  text_radix = RADIX_HEX;
  logic [1:0]  digit_radix = RADIX_BIN;
  logic [63:0] run_value = '0;
  logic [6:0]  run_digits = '0;
  logic        run_bad = 1'b0;
  logic [1:0]  run_pos = '0;
  logic        run_lead_zero = 1'b0;

  text_item_t  input_beats_q[$];
  digit_beat_t digit_beats_q[$];
  text_item_t  cur_item;
  int          beats_outstanding = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          quiet_cycles = 0;
  int          n_errors = 0;
  bit          calm = 1'b0;

  function automatic int radix_bits(logic [1:0] code);
    if (code == RADIX_BIN) return 1;
    if (code == RADIX_OCT) return 3;
    return 4;
  endfunction

  function automatic int radix_limit(logic [1:0] code);
    return (VALUE_BITS + radix_bits(code) - 1) / radix_bits(code);
  endfunction

  function automatic logic [7:0] prefix_letter(logic [1:0] code);
    if (code == RADIX_BIN) return CHAR_LB;
    if (code == RADIX_OCT) return CHAR_LO;
    return CHAR_LX;
  endfunction

  // Returns the digit value, or -1 when the character is not a digit of the radix.
  function automatic int digit_of(logic [1:0] code, logic [7:0] c);
    if (code == RADIX_BIN) return (c == CHAR_0 || c == CHAR_1) ? int'(c - CHAR_0) : -1;
    if (code == RADIX_OCT) return (c >= CHAR_0 && c <= CHAR_7) ? int'(c - CHAR_0) : -1;
    if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
    if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - LOWER_OFS);
    if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - UPPER_OFS);
    return -1;
  endfunction

  function automatic void queue_digits(logic [63:0] v, status_e st);
    int          b;
    int          n;
    logic [63:0] t;
    logic [63:0] d;
    digit_beat_t beat;
    if (v == '0) begin
      beat = '{ch: 8'd0, status: STATUS_ZERO, last: 1'b1};
      digit_beats_q.push_back(beat);
      return;
    end
    b = radix_bits(digit_radix);
    n = 0;
    t = v;
    while (t != '0) begin
      n++;
      t = t >> b;
    end
    for (int k = n - 1; k >= 0; k--) begin
      d = (v >> (k * b)) & ((64'd1 << b) - 1);
      beat.ch = (d < 10) ? CHAR_0 + 8'(d) : LOWER_OFS + 8'(d);
      beat.status = st;
      beat.last = (k == 0);
      digit_beats_q.push_back(beat);
    end
  endfunction

  function automatic void convert_item(text_item_t it);
    int          b;
    int          lim;
    int          d;
    bit          dropped;
    digit_beat_t beat;
    if (it.func == FUNC_FORMAT) begin
      queue_digits(it.number, STATUS_OK);
      return;
    end
    b = radix_bits(text_radix);
    lim = radix_limit(text_radix);
    dropped = 1'b0;
    if (run_pos == 2'd1 && run_lead_zero && it.symbol == prefix_letter(text_radix)) begin
      run_digits = '0;
      run_value = '0;
      dropped = 1'b1;
    end
    if (run_pos == 2'd0) run_lead_zero = (it.symbol == CHAR_0);
    if (!dropped) begin
      d = digit_of(text_radix, it.symbol);
      if (d < 0) begin
        run_bad = 1'b1;
      end else if (int'(run_digits) <= lim) begin
        run_value = (run_value << b) | 64'(d);
        run_digits++;
      end
    end
    if (run_pos < 2'd2) run_pos++;
    if (!it.eot) return;
    if (run_bad) begin
      beat = '{ch: 8'd0, status: STATUS_BAD, last: 1'b1};
      digit_beats_q.push_back(beat);
    end else if (int'(run_digits) > lim) begin
      queue_digits('1, STATUS_SAT);
    end else begin
      queue_digits(run_value, STATUS_OK);
    end
    run_value = '0;
    run_digits = '0;
    run_bad = 1'b0;
    run_pos = '0;
    run_lead_zero = 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_item(text_item_t it);
    input_beats_q.push_back(it);
    beats_outstanding++;
  endfunction

  function automatic void push_parse(logic [7:0] sym, logic eot);
    text_item_t it;
    it = '{func: FUNC_PARSE, symbol: sym, eot: eot, number: {$urandom, $urandom}};
    push_item(it);
  endfunction

  function automatic void push_format(logic [63:0] v);
    text_item_t it;
    it.func = FUNC_FORMAT;
    it.symbol = 8'($urandom_range(0, 255));
    it.eot = 1'($urandom_range(0, 1));
    it.number = v;
    push_item(it);
  endfunction

  function automatic void push_text(string s, bit eot_last);
    for (int i = 0; i < s.len(); i++) push_parse(s[i], eot_last && i == s.len() - 1);
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: v = '0;
      1: v = '1;
      2: v = v >> $urandom_range(1, 63);
      3: v = 64'($urandom_range(0, 255));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] rand_digit(logic [1:0] code);
    int v;
    if (code == RADIX_BIN) return CHAR_0 + 8'($urandom_range(0, 1));
    if (code == RADIX_OCT) return CHAR_0 + 8'($urandom_range(0, 7));
    v = $urandom_range(0, 15);
    if (v < 10) return CHAR_0 + 8'(v);
    return ($urandom_range(0, 1) ? LOWER_OFS : UPPER_OFS) + 8'(v);
  endfunction

  // Mostly well-formed digit strings, plus formats and stray characters.
  function automatic int add_random_run();
    text_item_t run_q[$];
    text_item_t it;
    int         r;
    int         lim;
    int         len;
    bit         with_prefix;
    logic [7:0] letters[3];
    r = $urandom_range(0, 99);
    if (r < 10) begin
      push_format(rand_value());
      return 1;
    end
    if (r < 18) begin
      push_parse(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      return 1;
    end
    lim = radix_limit(text_radix);
    letters = '{CHAR_LB, CHAR_LO, CHAR_LX};
    with_prefix = ($urandom_range(0, 3) == 0);
    it.func = FUNC_PARSE;
    it.eot = 1'b0;
    if (with_prefix) begin
      it.symbol = CHAR_0;
      it.number = {$urandom, $urandom};
      run_q.push_back(it);
      it.symbol = ($urandom_range(0, 4) != 0) ? prefix_letter(text_radix)
                                               : letters[$urandom_range(0, 2)];
      it.number = {$urandom, $urandom};
      run_q.push_back(it);
    end
    r = $urandom_range(0, 99);
    if (r < 4 && with_prefix) len = 0;
    else if (r < 70) len = $urandom_range(1, 6);
    else if (r < 85) len = $urandom_range(7, lim);
    else if (r < 95) len = lim;
    else len = $urandom_range(lim + 1, lim + 3);
    for (int i = 0; i < len; i++) begin
      it.symbol = rand_digit(text_radix);
      if ($urandom_range(0, 59) == 0) it.symbol = 8'($urandom_range(0, 255));
      it.number = {$urandom, $urandom};
      run_q.push_back(it);
    end
    run_q[run_q.size() - 1].eot = 1'b1;
    foreach (run_q[i]) push_item(run_q[i]);
    return run_q.size();
  endfunction

  task automatic wait_drained();
    while (beats_outstanding != 0 || digit_beats_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_SOURCE_RADIX) text_radix = val;
    else digit_radix = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic reconfigure(logic [1:0] src, logic [1:0] dst);
    wait_drained();
    // Let the block sit idle for a while before the registers change.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_SOURCE_RADIX, src);
    write_reg(CFG_DEST_RADIX, dst);
  endtask

  // Sender: holds each beat until accepted, with random gaps between beats.
  always @(posedge clk_i) begin
    logic hold;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      hold = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        convert_item(cur_item);
        beats_outstanding--;
        hold = 1'b0;
      end
      if (!hold) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (input_beats_q.size() != 0) begin
          cur_item = input_beats_q.pop_front();
          func_i <= cur_item.func;
          symbol_i <= cur_item.symbol;
          end_of_text_i <= cur_item.eot;
          number_i <= cur_item.number;
          hold = 1'b1;
          send_gap = pick_gap();
        end
      end
      in_valid_i <= hold;
    end
  end

  // Receiver: checks each digit beat against the oldest prediction.
  always @(posedge clk_i) begin
    digit_beat_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (digit_beats_q.size() == 0) begin
          $error("unexpected digit beat: digit_char %0d status %0d last_digit %0d",
                 digit_char_o, status_o, last_digit_o);
          n_errors++;
        end else begin
          want = digit_beats_q.pop_front();
          if (digit_char_o !== want.ch) begin
            $error("digit_char: expected %0d, got %0d", want.ch, digit_char_o);
            n_errors++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            n_errors++;
          end
          if (last_digit_o !== want.last) begin
            $error("last_digit: expected %0d, got %0d", want.last, last_digit_o);
            n_errors++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 25) recv_stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [1:0] src_plan[9];
    logic [1:0] dst_plan[9];
    int         added;
    bit         drained_once;
    src_plan = '{RADIX_OCT, RADIX_BIN, RADIX_HEX, RADIX_OCT, RADIX_BIN,
                 RADIX_ALT_HEX, RADIX_HEX, RADIX_OCT, RADIX_BIN};
    dst_plan = '{RADIX_HEX, RADIX_OCT, RADIX_HEX, RADIX_BIN, RADIX_BIN,
                 RADIX_ALT_HEX, RADIX_OCT, RADIX_OCT, RADIX_HEX};
    drained_once = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: hex text in, binary digits out.
    push_text("0x1F", 1'b1);
    push_text("AbC", 1'b1);
    push_text("0", 1'b1);
    push_text("0x", 1'b1);
    push_text("g", 1'b1);
    push_parse(8'hFF, 1'b1);
    push_format('0);
    push_format('1);
    push_format(64'd1);
    // A format beat in the middle of a text run must not disturb the run.
    push_text("1", 1'b0);
    push_format(64'h8000_0000_0000_0000);
    push_text("2", 1'b1);
    // Leave a run open across a change of both radixes.
    push_text("3", 1'b0);

    for (int p = 0; p < 9; p++) begin
      reconfigure(src_plan[p], dst_plan[p]);
      calm = (p == 2 || p == 6);
      if (p == 0) push_text("7", 1'b1);
      added = 0;
      while (added < 28) begin
        added += add_random_run();
        // Once, let the sender sit until every predicted digit has come out.
        if (p == 4 && !drained_once && added >= 14) begin
          wait_drained();
          drained_once = 1'b1;
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
